/* sv/mse_pkg.sv */
// mse_pkg: payload structs, controller states and the command/status
// structs shared by the merge sort engine modules. No dependencies.
package mse_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     final_item;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_result;
	} result_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_PASS_INIT,
		ST_MERGE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic pass_init;
		logic merge_step;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic set_end;
		logic sort_done;
		logic run_last;
		logic pass_last;
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

/* sv/mse_ctrl.sv */
// mse_ctrl: sequencer for load, merge passes and emit.
// Depends on mse_pkg; drives the command struct to mse_dp.
module mse_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mse_pkg::status_t status,
	output mse_pkg::cmd_t    cmd
);
	import mse_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (item_valid && status.set_end) begin
					state_d = ST_PASS_INIT;
				end
			end
			ST_PASS_INIT: begin
				state_d = status.sort_done ? ST_EMIT : ST_MERGE;
			end
			ST_MERGE: begin
				if (status.run_last && status.pass_last) begin
					state_d = ST_PASS_INIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free && status.emit_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				item_ready = 1'b1;
				cmd.load   = item_valid;
			end
			ST_PASS_INIT: begin
				cmd.pass_init = 1'b1;
			end
			ST_MERGE: begin
				cmd.merge_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit_step = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/mse_dp.sv */
// mse_dp: element store, merge scratch, run pointers, comparator and
// result register. Depends on mse_pkg; steered by mse_ctrl commands.
module mse_dp #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mse_pkg::item_t   item,
	input  mse_pkg::cmd_t    cmd,
	output mse_pkg::status_t status,
	input  logic             result_ready,
	output logic             result_valid,
	output mse_pkg::result_t result
);
	import mse_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] LAST_IDX = CW'(MAX_ELEMENTS - 1);

	logic [DATA_W-1:0] store_mem   [MAX_ELEMENTS];
	logic [DATA_W-1:0] scratch_mem [MAX_ELEMENTS];
	logic [DATA_W-1:0] store_ra_q, store_rb_q, scratch_ra_q, scratch_rb_q;

	logic [CW-1:0] count_q, n_q, a_q, b_q, mid_q, hi_q, k_q;
	logic [CW:0]   w_q;
	logic          src_sel_q;

	logic [CW-1:0]     a_d, b_d, base_pt, new_mid, new_hi;
	logic [SW-1:0]     sum_w, sum_2w;
	logic [DATA_W-1:0] head_a, head_b, merge_data, store_wd;
	logic [AW-1:0]     store_wa;
	logic              a_live, b_live, take_a, next_run, store_we, scratch_we;

	result_t result_q;
	logic    result_valid_q;

	// heads of the two runs come from whichever store is the source
	assign head_a = src_sel_q ? scratch_ra_q : store_ra_q;
	assign head_b = src_sel_q ? scratch_rb_q : store_rb_q;

	assign a_live     = a_q < mid_q;
	assign b_live     = b_q < hi_q;
	assign take_a     = a_live && (!b_live || ($signed(head_a) < $signed(head_b)));
	assign merge_data = take_a ? head_a : head_b;

	assign status.set_end   = item.final_item || (count_q == LAST_IDX);
	assign status.sort_done = w_q >= {1'b0, n_q};
	assign status.run_last  = (k_q + CW'(1)) == hi_q;
	assign status.pass_last = hi_q == n_q;
	assign status.out_free  = !result_valid_q || result_ready;
	assign status.emit_last = (a_q + CW'(1)) == n_q;

	assign next_run = status.run_last && !status.pass_last;

	// bounds of the next run pair, clipped to the set size
	assign base_pt = cmd.pass_init ? '0 : hi_q;
	assign sum_w   = SW'(base_pt) + SW'(w_q);
	assign sum_2w  = sum_w + SW'(w_q);
	assign new_mid = (sum_w < SW'(n_q)) ? sum_w[CW-1:0] : n_q;
	assign new_hi  = (sum_2w < SW'(n_q)) ? sum_2w[CW-1:0] : n_q;

	// read addresses follow the pointers' next values
	always_comb begin
		a_d = a_q;
		b_d = b_q;
		if (cmd.pass_init) begin
			a_d = '0;
			b_d = new_mid;
		end else if (cmd.merge_step) begin
			if (next_run) begin
				a_d = hi_q;
				b_d = new_mid;
			end else if (take_a) begin
				a_d = a_q + CW'(1);
			end else begin
				b_d = b_q + CW'(1);
			end
		end else if (cmd.emit_step) begin
			a_d = a_q + CW'(1);
		end
	end

	assign store_we   = cmd.load || (cmd.merge_step && src_sel_q);
	assign store_wa   = cmd.load ? count_q[AW-1:0] : k_q[AW-1:0];
	assign store_wd   = cmd.load ? item.value : merge_data;
	assign scratch_we = cmd.merge_step && !src_sel_q;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_wa] <= store_wd;
		end
		store_ra_q <= store_mem[a_d[AW-1:0]];
		store_rb_q <= store_mem[b_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (scratch_we) begin
			scratch_mem[k_q[AW-1:0]] <= merge_data;
		end
		scratch_ra_q <= scratch_mem[a_d[AW-1:0]];
		scratch_rb_q <= scratch_mem[b_d[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= status.set_end ? '0 : count_q + CW'(1);
			end
			if (cmd.emit_step) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
		if (cmd.load && status.set_end) begin
			n_q       <= count_q + CW'(1);
			w_q       <= (CW + 1)'(1);
			src_sel_q <= 1'b0;
		end
		if (cmd.pass_init) begin
			mid_q <= new_mid;
			hi_q  <= new_hi;
			k_q   <= '0;
		end
		if (cmd.merge_step) begin
			k_q <= k_q + CW'(1);
			if (status.run_last) begin
				if (status.pass_last) begin
					w_q       <= w_q << 1;
					src_sel_q <= !src_sel_q;
				end else begin
					mid_q <= new_mid;
					hi_q  <= new_hi;
				end
			end
		end
		if (cmd.emit_step) begin
			result_q.sorted_value <= head_a;
			result_q.final_result <= status.emit_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* sv/merge_sort_engine.sv */
// merge_sort_engine: top level, mse_ctrl sequencer plus mse_dp datapath.
// Load: items are taken while in the load state. After the set-ending item of n
// elements: ceil(log2 n) merge passes, each a pass-init step then n merge steps,
// then a final pass check, then n emit steps (one per result while the sink
// takes them). Each merge step writes one element, set by the one-write merge store.
// Reset clears sequencer, element count and result valid, not the stores.
module merge_sort_engine #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mse_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output mse_pkg::result_t result
);
	import mse_pkg::*;

	cmd_t    cmd;
	status_t status;

	mse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	mse_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> (!result_valid || result_ready))
		else $error("result register overwritten before transfer");

	a_pass_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.merge_step && status.run_last && status.pass_last) |=> cmd.pass_init)
		else $error("merge pass not followed by pass init");

	a_final_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.final_item) |=> !item_ready)
		else $error("input taken after set end");

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.pass_init, cmd.merge_step, cmd.emit_step}))
		else $error("conflicting datapath commands");

endmodule
